FILE: rtl/endpoint_receive_ring_fifos_macros.svh
// Assertion macros shared by the receive ring FIFO modules.
`ifndef ENDPOINT_RECEIVE_RING_FIFOS_MACROS_SVH
`define ENDPOINT_RECEIVE_RING_FIFOS_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ERF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("erf assertion failed");
// Next-cycle implication, checked out of reset.
`define ERF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("erf assertion failed");
`else
`define ERF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ERF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/erf_pkg.sv
// Types and constants shared by the receive ring FIFO modules.
package erf_pkg;

    // Operation codes of the func field.
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_EP  = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_NOT_OUT = 3'd4;

    // Register map: word index taken from paddr[2].
    localparam logic REG_OUT_SLOT_MASK = 1'b0;
    localparam int   PADDR_W           = 3;

    // Width that holds any ring count before it is cut to the output field.
    localparam int CNT_EXT_W = 9;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] endpoint;
        logic [7:0] push_byte;
    } req_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] pop_byte;
        logic [5:0] available;
    } rsp_word_t;

    // Result of the index update, handed to the output stage.
    typedef struct packed {
        logic [2:0] status;
        logic       pop_ok;
        logic [5:0] available;
    } erf_resp_t;

endpackage

FILE: rtl/erf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module erf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/erf_ring_ctrl.sv
// Endpoint decode, ring index registers and ring memory access.
`include "endpoint_receive_ring_fifos_macros.svh"

module erf_ring_ctrl
    import erf_pkg::*;
#(
    parameter int ENDPOINT_COUNT = 8,
    parameter int FIRST_DYNAMIC  = 4,
    parameter int RING_DEPTH     = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  req_word_t req,
    input  logic [3:0] out_slot_mask,
    output erf_resp_t resp,
    output logic [7:0] ram_rdata
);

    localparam int SLOT_COUNT = (ENDPOINT_COUNT > FIRST_DYNAMIC) ?
                                (ENDPOINT_COUNT - FIRST_DYNAMIC) : 1;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int ADDR_W     = SLOT_W + IDX_W;

    logic [IDX_W-1:0]  wr_idx_reg [SLOT_COUNT];
    logic [IDX_W-1:0]  rd_idx_reg [SLOT_COUNT];
    logic [2:0]        slot_full;
    logic [SLOT_W-1:0] slot;
    logic              dynamic_ep;
    logic              is_out;
    logic [IDX_W-1:0]  cur_w;
    logic [IDX_W-1:0]  cur_r;
    logic [IDX_W-1:0]  next_w;
    logic [IDX_W-1:0]  next_r;
    logic [IDX_W-1:0]  new_w;
    logic [IDX_W-1:0]  new_r;
    logic              push_ok;
    logic              pop_ok;
    logic [IDX_W-1:0]  count;
    logic [CNT_EXT_W-1:0] count_ext;
    logic [2:0]        status;

    // Advance a ring index with wrap at the ring depth.
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] v);
        logic [IDX_W-1:0] r;
        if ({1'b0, v} == (IDX_W + 1)'(RING_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = v + IDX_W'(1);
        end
        return r;
    endfunction

    // Bytes waiting between a read and a write index.
    function automatic logic [IDX_W-1:0] ring_count(input logic [IDX_W-1:0] w,
                                                    input logic [IDX_W-1:0] r);
        logic [IDX_W:0] sum;
        if (w >= r)
        begin
            sum = {1'b0, w} - {1'b0, r};
        end
        else
        begin
            sum = {1'b0, w} + (IDX_W + 1)'(RING_DEPTH) - {1'b0, r};
        end
        return sum[IDX_W-1:0];
    endfunction

    // Endpoint decode and slot type.
    always_comb
    begin
        dynamic_ep = (req.endpoint >= 3'(FIRST_DYNAMIC)) &&
                     ({1'b0, req.endpoint} < 4'(ENDPOINT_COUNT));
        slot_full  = req.endpoint - 3'(FIRST_DYNAMIC);
        slot       = slot_full[SLOT_W-1:0];
        is_out     = (slot_full < 3'd4) && out_slot_mask[slot_full[1:0]];
    end

    // Index lookup, full and empty checks, and the new indices.
    always_comb
    begin
        cur_w   = wr_idx_reg[slot];
        cur_r   = rd_idx_reg[slot];
        next_w  = ring_next(cur_w);
        next_r  = ring_next(cur_r);
        push_ok = 1'b0;
        pop_ok  = 1'b0;
        status  = ST_OK;
        if (!dynamic_ep)
        begin
            status = ST_BAD_EP;
        end
        else
        begin
            case (req.func)
                FUNC_PUSH:
                begin
                    if (!is_out)
                    begin
                        status = ST_NOT_OUT;
                    end
                    else if (next_w == cur_r)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        push_ok = 1'b1;
                    end
                end
                FUNC_POP:
                begin
                    if (cur_r == cur_w)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        pop_ok = 1'b1;
                    end
                end
                default:
                begin
                    // Query and the unused code only report the count.
                    status = ST_OK;
                end
            endcase
        end
        new_w     = push_ok ? next_w : cur_w;
        new_r     = pop_ok ? next_r : cur_r;
        count     = ring_count(new_w, new_r);
        count_ext = CNT_EXT_W'(count);
    end

    // Response for the output stage.
    always_comb
    begin
        resp.status    = status;
        resp.pop_ok    = pop_ok;
        resp.available = dynamic_ep ? count_ext[5:0] : 6'd0;
    end

    // Index registers: written only when an item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                wr_idx_reg[i] <= '0;
                rd_idx_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            if (push_ok)
            begin
                wr_idx_reg[slot] <= next_w;
            end
            if (pop_ok)
            begin
                rd_idx_reg[slot] <= next_r;
            end
        end
    end

    // Ring storage: one row of RING_DEPTH bytes per slot.
    erf_ram #(
        .WIDTH (8),
        .DEPTH (2 ** ADDR_W)
    ) u_ring_ram (
        .clk   (clk),
        .we    (take && push_ok),
        .waddr ({slot, cur_w}),
        .wdata (req.push_byte),
        .re    (take && pop_ok),
        .raddr ({slot, cur_r}),
        .rdata (ram_rdata)
    );

    // A push and a pop never touch the memory in the same cycle.
    `ERF_ASSERT_IMP(a_one_access, clk, rst_n, take, !(push_ok && pop_ok))
    // Indices stay inside the ring.
    `ERF_ASSERT_IMP(a_idx_range, clk, rst_n, 1'b1,
                    ({1'b0, cur_w} < (IDX_W + 1)'(RING_DEPTH)) &&
                    ({1'b0, cur_r} < (IDX_W + 1)'(RING_DEPTH)))

endmodule

FILE: rtl/erf_out_stage.sv
// Memory read stage and output register of the response channel.
`include "endpoint_receive_ring_fifos_macros.svh"

module erf_out_stage
    import erf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  erf_resp_t  resp,
    input  logic [7:0] ram_rdata,
    output logic       ready,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_word_t  rsp
);

    logic      s1_valid_reg;
    erf_resp_t s1_resp_reg;
    logic      rsp_valid_reg;
    rsp_word_t rsp_reg;
    logic      s1_adv;

    // The read stage moves on when the output register is free or being taken.
    assign s1_adv = !rsp_valid_reg || !rsp_stall;
    assign ready  = !s1_valid_reg || s1_adv;

    // Read stage: holds the response while the ring memory read data is registered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && take)
        begin
            s1_resp_reg <= resp;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            rsp_reg.status    <= s1_resp_reg.status;
            rsp_reg.pop_byte  <= s1_resp_reg.pop_ok ? ram_rdata : 8'd0;
            rsp_reg.available <= s1_resp_reg.available;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A word held in the read stage is not lost while the output is stalled.
    `ERF_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && rsp_valid_reg && rsp_stall,
                     s1_valid_reg)
    // Only a successful pop carries a byte.
    `ERF_ASSERT_IMP(a_pop_byte_zero, clk, rst_n, rsp_valid_reg && (rsp_reg.status != ST_OK),
                    rsp_reg.pop_byte == 8'd0)
    // An invalid endpoint reports no bytes waiting.
    `ERF_ASSERT_IMP(a_bad_ep_count, clk, rst_n,
                    rsp_valid_reg && (rsp_reg.status == ST_BAD_EP),
                    rsp_reg.available == 6'd0)

endmodule

FILE: rtl/endpoint_receive_ring_fifos.sv
// Top level of the per-endpoint receive ring FIFOs.
//
// Request channel (req_valid, req_stall, req): one word per operation, with a
// func code (push byte, pop byte, query count), an endpoint number and a byte.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one word per request,
// in request order, with a status, the popped byte and the bytes waiting.
// Each dynamic endpoint owns a ring of RING_DEPTH bytes in one shared RAM,
// holding at most RING_DEPTH-1 bytes; a push to a full ring is dropped.
// From request to response: the index update and the RAM access, then the read
// stage with the registered RAM read data, then the output register.
// Throughput is one request per cycle while the receiver does not stall, set by
// the single RAM access and the single index update that each request needs.
// Reset clears all ring indices and the OUT slot mask; ring contents are not
// cleared and need no clearing pass, since only written bytes are ever read.
// When the receiver stalls, the response holds, one more response waits in
// the read stage, and then req_stall rises until the output moves again.
// The APB port holds one register, out_slot_mask, at byte address 0; the user
// must write it only while no request is in flight (not enforced by the block).
module endpoint_receive_ring_fifos
    import erf_pkg::*;
#(
    parameter int ENDPOINT_COUNT = 8,
    parameter int FIRST_DYNAMIC  = 4,
    parameter int RING_DEPTH     = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_word_t          req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_word_t          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [3:0] out_slot_mask_reg;
    logic       stage_ready;
    logic       take;
    erf_resp_t  resp;
    logic [7:0] ram_rdata;

    assign req_stall = !stage_ready;
    assign take      = req_valid && stage_ready;

    // Configuration register.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_slot_mask_reg <= 4'd0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_OUT_SLOT_MASK))
        begin
            out_slot_mask_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_OUT_SLOT_MASK)
        begin
            prdata = 32'(out_slot_mask_reg);
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    // Decode, index update and ring memory.
    erf_ring_ctrl #(
        .ENDPOINT_COUNT (ENDPOINT_COUNT),
        .FIRST_DYNAMIC  (FIRST_DYNAMIC),
        .RING_DEPTH     (RING_DEPTH)
    ) u_ring_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .req           (req),
        .out_slot_mask (out_slot_mask_reg),
        .resp          (resp),
        .ram_rdata     (ram_rdata)
    );

    // Read stage and output register.
    erf_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .resp      (resp),
        .ram_rdata (ram_rdata),
        .ready     (stage_ready),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
